@@ hw/rtl/strs_pkg.sv @@
// Shared types and constants for the sparse triangular row solver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package strs_pkg;

    // Store and number format
    localparam int MAX_ROWS  = 4096;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int FRAC_BITS = 20;
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int RC_W      = 13;
    localparam int SUM_W     = 48;
    localparam int PROD_W    = 2 * VAL_W;
    // Difference b - sum, and the long-division numerator (|d| << FRAC_BITS)
    localparam int DIFF_W    = SUM_W + 1;
    localparam int DIV_W     = 63;
    localparam int DCNT_W    = $clog2(DIV_W);

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_MATRIX = 2'd1;
    localparam logic [1:0] OP_RESP   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_RHS = 2'd0;
    localparam logic [1:0] KIND_REQ = 2'd1;
    localparam logic [1:0] KIND_SOL = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    end_of_matrix;
    } item_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        position;
        logic signed [VAL_W-1:0] amount;
        logic                    fault;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/strs_rhs_ram.sv @@
// Right-hand-side store: single-port-write, registered-read memory with a
// clearing sweep after reset. Depends on strs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strs_rhs_ram
    import strs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic signed [VAL_W-1:0] wdata,
    input  wire logic                    re,
    input  wire logic [ADDR_W-1:0]       raddr,
    output logic signed [VAL_W-1:0]      rdata,
    output logic                         clearing
);

    logic signed [VAL_W-1:0] mem [MAX_ROWS];
    logic [ADDR_W:0]         clr_reg;
    logic [ADDR_W:0]         clr_next;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic signed [VAL_W-1:0] rdata_reg;

    // Sweep counter: top bit set once every entry has been zeroed
    assign clearing = ~clr_reg[ADDR_W];
    assign clr_next = clearing ? clr_reg + 1'b1 : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    // Write port shared between the sweep and normal loads
    always_comb
    begin
        wr_en   = we;
        wr_addr = waddr;
        wr_data = wdata;
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[ADDR_W-1:0];
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/strs_mac.sv @@
// Multiply-accumulate for the row sum: registered 32x32 product, then
// floor shift and saturating 48-bit add. Depends on strs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strs_mac
    import strs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    start,
    input  wire logic signed [VAL_W-1:0] response,
    input  wire logic signed [VAL_W-1:0] coefficient,
    input  wire logic signed [SUM_W-1:0] sum_in,
    output logic signed [SUM_W-1:0]      sum_out
);

    localparam int S_W = SUM_W + 2;
    localparam logic signed [S_W-1:0] SUM_MAX = S_W'({1'b0, {(SUM_W-1){1'b1}}});
    localparam logic signed [S_W-1:0] SUM_MIN = -SUM_MAX - 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [S_W-1:0]    total;

    // Stage 1: product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= response * coefficient;
        end
    end

    // Stage 2: arithmetic shift rounds toward minus infinity, then clamp
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign total   = S_W'(sum_in) + S_W'(prod_sh);

    always_comb
    begin
        if (total > SUM_MAX)
        begin
            sum_out = SUM_MAX[SUM_W-1:0];
        end
        else if (total < SUM_MIN)
        begin
            sum_out = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            sum_out = total[SUM_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/strs_div.sv @@
// Fixed-point divider for the diagonal step: x = (d << FRAC_BITS) / diag,
// restoring, one quotient bit per cycle, saturating. Depends on strs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strs_div
    import strs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DIFF_W-1:0] dividend,
    input  wire logic signed [VAL_W-1:0]  divisor,
    input  wire logic                     take,
    output logic                          valid,
    output logic signed [VAL_W-1:0]       x,
    output logic                          fault
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_PREP = 5'b00010,
        D_ITER = 5'b00100,
        D_FIN  = 5'b01000,
        D_DONE = 5'b10000
    } dstate_t;

    localparam logic signed [DIFF_W-1:0] D_LIM =
        DIFF_W'(64'sd1 <<< (62 - FRAC_BITS));
    localparam logic [DIV_W-1:0] Q_NEG_LIM = DIV_W'(64'd1 << (VAL_W - 1));
    localparam logic [DIV_W-1:0] Q_POS_LIM = Q_NEG_LIM - 1'b1;
    localparam logic signed [VAL_W-1:0] X_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] X_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    dstate_t                  state_reg, state_next;
    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic signed [VAL_W-1:0]  dv_reg, dv_next;
    logic                     neg_reg, neg_next;
    logic [DIV_W-1:0]         num_reg, num_next;
    logic [VAL_W-1:0]         den_reg, den_next;
    logic [VAL_W-1:0]         rem_reg, rem_next;
    logic [DCNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VAL_W-1:0]  x_reg, x_next;
    logic                     fault_reg, fault_next;

    logic [DIFF_W-1:0]        d_mag;
    logic [VAL_W:0]           rem_sh;
    logic [VAL_W:0]           rem_sub;
    logic                     ge;

    assign d_mag   = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
    assign rem_sh  = {rem_reg, num_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        dv_next    = dv_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        fault_next = fault_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    d_next     = dividend;
                    dv_next    = divisor;
                    state_next = D_PREP;
                end
            end
            D_PREP:
            begin
                // zero divisor and out-of-range difference finish at once
                neg_next = d_reg[DIFF_W-1] ^ dv_reg[VAL_W-1];
                if (dv_reg == '0)
                begin
                    x_next     = '0;
                    fault_next = 1'b1;
                    state_next = D_DONE;
                end
                else if (d_reg > D_LIM || d_reg < -D_LIM)
                begin
                    x_next     = (d_reg[DIFF_W-1] ^ dv_reg[VAL_W-1]) ? X_MIN : X_MAX;
                    fault_next = 1'b1;
                    state_next = D_DONE;
                end
                else
                begin
                    num_next   = DIV_W'(d_mag) << FRAC_BITS;
                    den_next   = dv_reg[VAL_W-1] ? VAL_W'(-dv_reg) : VAL_W'(dv_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                // quotient bits shift into the numerator register
                rem_next = ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
                num_next = {num_reg[DIV_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    fault_next = num_reg > Q_NEG_LIM;
                    x_next     = (num_reg > Q_NEG_LIM) ? X_MIN
                                                        : VAL_W'(-num_reg[VAL_W-1:0]);
                end
                else
                begin
                    fault_next = num_reg > Q_POS_LIM;
                    x_next     = (num_reg > Q_POS_LIM) ? X_MAX : num_reg[VAL_W-1:0];
                end
                state_next = D_DONE;
            end
            D_DONE:
            begin
                if (take)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        dv_reg    <= dv_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        fault_reg <= fault_next;
    end

    assign valid = (state_reg == D_DONE);
    assign x     = x_reg;
    assign fault = fault_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sparse_triangular_row_solver.sv @@
// Flow: b loads and solution requests are pushed into the result queue when accepted;
// a response passes through the accumulate state and a row header through a store read first.
// A diagonal entry waits for the bit-serial divider (63 iterations) and for queue space.
// Items are taken one at a time, only in the idle state and while the result queue has room.
// Reset: rst_n asynchronous; afterwards a sweep zeroes every b store entry while
// items stall (configuration writes are taken throughout). Depends on strs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sparse_triangular_row_solver
    import strs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [RC_W-1:0]  cfg_data,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HDR   = 5'b00100,
        S_MAC   = 5'b01000,
        S_DIV   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [RC_W-1:0]         row_count_reg;
    logic                    row_open_reg, row_open_next;
    logic                    awaiting_reg, awaiting_next;
    logic [IDX_W-1:0]        active_row_reg, active_row_next;
    logic signed [VAL_W-1:0] active_rhs_reg, active_rhs_next;
    logic signed [VAL_W-1:0] held_coef_reg, held_coef_next;
    logic signed [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic                    hdr_in_store_reg, hdr_in_store_next;

    // Two-entry result queue
    result_t                 q_reg [2];
    result_t                 q_next [2];
    logic [1:0]              cnt_reg, cnt_next;
    logic                    push_en;
    result_t                 push_data;
    logic                    pop;

    logic                    accept;
    logic                    idx_in_store;
    logic                    load_ok;
    logic                    ram_we;
    logic                    ram_re;
    logic signed [VAL_W-1:0] ram_rdata;
    logic                    clearing;
    logic                    mac_start;
    logic signed [SUM_W-1:0] mac_sum;
    logic                    div_start;
    logic                    div_take;
    logic                    div_valid;
    logic signed [VAL_W-1:0] div_x;
    logic                    div_fault;
    logic signed [DIFF_W-1:0] diff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_count_reg <= cfg_data;
        end
    end

    // Handshake and range checks
    assign item_stall   = (state_reg != S_IDLE) || (cnt_reg == 2'd2);
    assign accept       = item_valid && !item_stall;
    assign idx_in_store = 32'(item.index) < 32'(MAX_ROWS);
    assign load_ok      = ({1'b0, item.index} < row_count_reg) && idx_in_store;
    assign diff         = DIFF_W'(active_rhs_reg) - DIFF_W'(row_sum_reg);

    strs_rhs_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (ram_we),
        .waddr    (item.index[ADDR_W-1:0]),
        .wdata    (item.value),
        .re       (ram_re),
        .raddr    (item.index[ADDR_W-1:0]),
        .rdata    (ram_rdata),
        .clearing (clearing)
    );

    strs_mac u_mac (
        .clk         (clk),
        .start       (mac_start),
        .response    (item.value),
        .coefficient (held_coef_reg),
        .sum_in      (row_sum_reg),
        .sum_out     (mac_sum)
    );

    strs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (item.value),
        .take     (div_take),
        .valid    (div_valid),
        .x        (div_x),
        .fault    (div_fault)
    );

    // Main sequencer
    always_comb
    begin
        state_next        = state_reg;
        row_open_next     = row_open_reg;
        awaiting_next     = awaiting_reg;
        active_row_next   = active_row_reg;
        active_rhs_next   = active_rhs_reg;
        held_coef_next    = held_coef_reg;
        row_sum_next      = row_sum_reg;
        hdr_in_store_next = hdr_in_store_reg;
        push_en           = 1'b0;
        push_data         = '0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        mac_start         = 1'b0;
        div_start         = 1'b0;
        div_take          = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.operation)
                        OP_LOAD:
                        begin
                            if (load_ok)
                            begin
                                ram_we    = 1'b1;
                                push_en   = 1'b1;
                                push_data = '{KIND_RHS, item.index, item.value, 1'b0};
                            end
                        end
                        OP_RESP:
                        begin
                            if (awaiting_reg)
                            begin
                                awaiting_next = 1'b0;
                                mac_start     = 1'b1;
                                state_next    = S_MAC;
                            end
                        end
                        OP_MATRIX:
                        begin
                            if (!awaiting_reg)
                            begin
                                if (!row_open_reg)
                                begin
                                    // row header: fetch its b entry
                                    active_row_next   = item.index;
                                    row_sum_next      = '0;
                                    row_open_next     = !item.end_of_matrix;
                                    hdr_in_store_next = idx_in_store;
                                    ram_re            = 1'b1;
                                    state_next        = S_HDR;
                                end
                                else if (item.index == active_row_reg)
                                begin
                                    // diagonal: divide, row closes
                                    div_start     = 1'b1;
                                    row_open_next = 1'b0;
                                    row_sum_next  = '0;
                                    state_next    = S_DIV;
                                end
                                else
                                begin
                                    // off-diagonal: request x at this column
                                    held_coef_next = item.value;
                                    awaiting_next  = !item.end_of_matrix;
                                    push_en        = 1'b1;
                                    push_data      = '{KIND_REQ, item.index, '0, 1'b0};
                                    if (item.end_of_matrix)
                                    begin
                                        row_open_next = 1'b0;
                                        row_sum_next  = '0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                active_rhs_next = hdr_in_store_reg ? ram_rdata : '0;
                state_next      = S_IDLE;
            end
            S_MAC:
            begin
                row_sum_next = mac_sum;
                state_next   = S_IDLE;
            end
            S_DIV:
            begin
                if (div_valid && cnt_reg != 2'd2)
                begin
                    div_take   = 1'b1;
                    push_en    = 1'b1;
                    push_data  = '{KIND_SOL, active_row_reg, div_x, div_fault};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            row_open_reg     <= 1'b0;
            awaiting_reg     <= 1'b0;
            active_row_reg   <= '0;
            active_rhs_reg   <= '0;
            held_coef_reg    <= '0;
            row_sum_reg      <= '0;
            hdr_in_store_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_open_reg     <= row_open_next;
            awaiting_reg     <= awaiting_next;
            active_row_reg   <= active_row_next;
            active_rhs_reg   <= active_rhs_next;
            held_coef_reg    <= held_coef_next;
            row_sum_reg      <= row_sum_next;
            hdr_in_store_reg <= hdr_in_store_next;
        end
    end

    // Result queue: pop from the head, push behind what remains
    assign pop = result_valid && !result_stall;

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 1'b1;
        end
        if (push_en)
        begin
            q_next[cnt_next[0]] = push_data;
            cnt_next            = cnt_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = q_reg[0];

    // Waiting for a response only happens inside an open row
    a_await_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> row_open_reg)
        else $error("awaiting a response with no open row");

    // Queue never overfills
    a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // An accepted response while one is awaited always starts the accumulate step
    a_mac_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_RESP && awaiting_reg) |=> state_reg == S_MAC)
        else $error("response did not start the accumulate step");

    // A finished division is delivered only when the queue has room
    a_div_push: assert property (@(posedge clk) disable iff (!rst_n)
        div_take |-> (cnt_reg != 2'd2 && state_reg == S_DIV))
        else $error("division result taken without queue space");

endmodule

`default_nettype wire

@@ tb/tb_sparse_triangular_row_solver.sv @@
// Self-checking testbench for sparse_triangular_row_solver: forward-substitution predictor,
// random idle/stall on both channels, row_count sweeps. Depends on strs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sparse_triangular_row_solver;

    import strs_pkg::*;

    // Unused operation code, ignored by the block
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Q11.20 constants and saturation limits
    localparam logic [31:0] Q_ONE    = 32'h0010_0000;
    localparam longint      X_MAX    = 64'sd2147483647;
    localparam longint      X_MIN    = -64'sd2147483648;
    localparam longint      SUM_MAX  = (64'sd1 <<< 47) - 64'sd1;
    localparam longint      SUM_MIN  = -(64'sd1 <<< 47);
    localparam longint      DIFF_LIM = 64'sd1 <<< (62 - FRAC_BITS);

    // Solver state mirror plus the queue of results still to arrive
    class fwd_subst_scoreboard;
        int               b_store [MAX_ROWS];
        bit               row_live;
        bit               waiting_x;
        bit [IDX_W-1:0]   cur_row;
        int               cur_b;
        int               coef;
        longint           acc;
        int               rows_in_use;
        result_t          pending [$];
        int               mismatches;
        int               n_rhs;
        int               n_req;
        int               n_sol;
        int               n_fault;

        function void set_rows(int n);
            rows_in_use = n;
        endfunction

        function void queue_result(logic [1:0] k, logic [IDX_W-1:0] pos, logic [31:0] amt,
                                   logic flt);
            result_t r;
            r.kind     = k;
            r.position = pos;
            r.amount   = amt;
            r.fault    = flt;
            pending.push_back(r);
        endfunction

        function void drop_row();
            row_live  = 1'b0;
            waiting_x = 1'b0;
            acc       = 0;
        endfunction

        // Update the mirror for one accepted input transaction
        function void note_item(item_t it);
            longint prod;
            longint s;
            longint d;
            longint q;
            longint x;
            int     diag;
            bit     flt;
            bit     neg;
            case (it.operation)
                OP_LOAD:
                begin
                    if (it.index < rows_in_use)
                    begin
                        b_store[it.index] = it.value;
                        queue_result(KIND_RHS, it.index, it.value, 1'b0);
                    end
                end
                OP_RESP:
                begin
                    if (waiting_x)
                    begin
                        waiting_x = 1'b0;
                        prod = longint'($signed(it.value)) * longint'(coef);
                        // arithmetic shift floors toward minus infinity
                        s = acc + (prod >>> FRAC_BITS);
                        if (s > SUM_MAX)
                            s = SUM_MAX;
                        else if (s < SUM_MIN)
                            s = SUM_MIN;
                        acc = s;
                    end
                end
                OP_MATRIX:
                begin
                    if (waiting_x)
                        ;   // dropped while a solution value is outstanding
                    else if (!row_live)
                    begin
                        cur_row  = it.index;
                        cur_b    = b_store[it.index];
                        acc      = 0;
                        row_live = 1'b1;
                        if (it.end_of_matrix)
                            drop_row();
                    end
                    else if (it.index == cur_row)
                    begin
                        // diagonal: x = (b - sum) / diag, truncated, saturated
                        diag = $signed(it.value);
                        d    = longint'(cur_b) - acc;
                        neg  = (d < 0) != (diag < 0);
                        if (diag == 0)
                        begin
                            x   = 0;
                            flt = 1'b1;
                        end
                        else if (d > DIFF_LIM || d < -DIFF_LIM)
                        begin
                            x   = neg ? X_MIN : X_MAX;
                            flt = 1'b1;
                        end
                        else
                        begin
                            q   = (d <<< FRAC_BITS) / longint'(diag);
                            flt = (q > X_MAX) || (q < X_MIN);
                            x   = (q > X_MAX) ? X_MAX : (q < X_MIN) ? X_MIN : q;
                        end
                        queue_result(KIND_SOL, cur_row, x[31:0], flt);
                        drop_row();
                    end
                    else
                    begin
                        coef      = $signed(it.value);
                        waiting_x = 1'b1;
                        queue_result(KIND_REQ, it.index, 32'h0, 1'b0);
                        if (it.end_of_matrix)
                            drop_row();
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 200)
                $display("ERROR @%0t: %s", $time, what);
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d position %0d amount %h",
                                 got.kind, got.position, got.amount));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.position !== want.position)
                report($sformatf("position %0d, want %0d", got.position, want.position));
            if (got.amount !== want.amount)
                report($sformatf("amount %h, want %h (position %0d)",
                                 got.amount, want.amount, want.position));
            if (got.fault !== want.fault)
                report($sformatf("fault %b, want %b (position %0d)",
                                 got.fault, want.fault, want.position));
            case (want.kind)
                KIND_RHS: n_rhs++;
                KIND_REQ: n_req++;
                default:  n_sol++;
            endcase
            if (want.fault)
                n_fault++;
        endtask
    endclass

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [RC_W-1:0]   cfg_data     = '0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;

    fwd_subst_scoreboard sb;
    bit                calm;
    int                freeze_cycles;
    int                rows_now;
    int                useful;
    int                n_sent;
    int                n_settings;

    sparse_triangular_row_solver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("ERROR: timeout with %0d results outstanding", sb.pending.size());
        $display("status: fail");
        $finish;
    end

    // Result side: per-transaction stall draw, plus long freezes on request
    initial
    begin
        int unsigned hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                sb.check_result(result);
                hold = calm ? 0 : $urandom_range(0, 11);
            end
            if (freeze_cycles > 0)
            begin
                freeze_cycles--;
                result_stall <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    function automatic item_t mk(logic [1:0] op, int idx, logic [31:0] val, bit last);
        item_t it;
        it.operation     = op;
        it.index         = idx[IDX_W-1:0];
        it.value         = val;
        it.end_of_matrix = last;
        return it;
    endfunction

    // Mostly modest Q11.20 magnitudes, with extremes and full-range values mixed in
    function automatic logic [31:0] rand_fixed();
        logic [31:0] v;
        v = $urandom_range(0, 32'h00FF_FFFF);
        case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0;
            3, 4:    v = $urandom();
            5, 6:    v = -v;
            default: ;
        endcase
        return v;
    endfunction

    function automatic int pick_row();
        if (rows_now == 0 || $urandom_range(0, 15) == 0)
            return $urandom_range(0, MAX_ROWS - 1);
        return $urandom_range(0, rows_now - 1);
    endfunction

    // Drive one input transaction; valid stays high into a back-to-back transaction
    task automatic offer_item(item_t it);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic set_row_count(int n);
        cfg_data  <= n[RC_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_rows(n);
        rows_now = n;
        n_settings++;
    endtask

    // Stop offering, let all results drain, then cover headers/responses still in flight
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_rhs(int n);
        int i;
        int idx;
        for (i = 0; i < n; i++)
        begin
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_ROWS - 1) : pick_row();
            offer_item(mk(OP_LOAD, idx, rand_fixed(), 1'($urandom_range(0, 1))));
            if (idx < rows_now)
                useful++;
        end
    endtask

    // Well-formed row: header, entry/response pairs, diagonal
    task automatic solve_row();
        int r;
        int col;
        int k;
        int nk;
        logic [31:0] diag;
        r  = pick_row();
        nk = $urandom_range(0, 4);
        offer_item(mk(OP_MATRIX, r, $urandom(), 1'b0));
        for (k = 0; k < nk; k++)
        begin
            col = pick_row();
            if (col == r)
                col = r ^ 1;
            offer_item(mk(OP_MATRIX, col, rand_fixed(), 1'b0));
            offer_item(mk(OP_RESP, $urandom_range(0, MAX_ROWS - 1), rand_fixed(), 1'b0));
        end
        diag = ($urandom_range(0, 19) == 0) ? 32'h0 : rand_fixed();
        offer_item(mk(OP_MATRIX, r, diag, $urandom_range(0, 7) == 0));
        useful += 2 + 2 * nk;
    endtask

    // Abandoned, interrupted or out-of-order rows
    task automatic broken_row();
        int r;
        int col;
        r   = pick_row();
        col = r ^ 1;
        case ($urandom_range(0, 3))
            0: offer_item(mk(OP_MATRIX, r, $urandom(), 1'b1));
            1:
            begin
                offer_item(mk(OP_MATRIX, r, $urandom(), 1'b0));
                offer_item(mk(OP_MATRIX, col, rand_fixed(), 1'b1));
                offer_item(mk(OP_RESP, col, rand_fixed(), 1'b0));
            end
            2:
            begin
                offer_item(mk(OP_MATRIX, r, $urandom(), 1'b0));
                offer_item(mk(OP_MATRIX, col, rand_fixed(), 1'b0));
                offer_item(mk(OP_MATRIX, r, rand_fixed(), 1'b0));
                offer_item(mk(OP_RESP, col, rand_fixed(), 1'b0));
                offer_item(mk(OP_MATRIX, r, rand_fixed(), 1'b0));
            end
            default:
            begin
                offer_item(mk(OP_RESP, r, rand_fixed(), 1'b0));
                offer_item(mk(OP_SPARE, r, $urandom(), 1'($urandom_range(0, 1))));
            end
        endcase
    endtask

    // Random transactions, then a response and an end-marked matrix item to close any row
    task automatic noise();
        int i;
        for (i = $urandom_range(1, 4); i > 0; i--)
            offer_item(mk(2'($urandom_range(0, 3)), $urandom_range(0, MAX_ROWS - 1),
                          $urandom(), 1'($urandom_range(0, 1))));
        offer_item(mk(OP_RESP, $urandom_range(0, MAX_ROWS - 1), rand_fixed(), 1'b0));
        offer_item(mk(OP_MATRIX, $urandom_range(0, MAX_ROWS - 1), rand_fixed(), 1'b1));
    endtask

    // Main sequence
    initial
    begin
        int p;
        int rows;
        int target;
        bit paused_once;
        sb = new();
        paused_once = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, eight rows in use
        set_row_count(8);
        offer_item(mk(OP_LOAD, 0, 32'h7FFF_FFFF, 1'b0));
        offer_item(mk(OP_LOAD, 7, 32'h8000_0000, 1'b0));
        offer_item(mk(OP_LOAD, 8, 32'h0000_1234, 1'b0));        // beyond row_count
        offer_item(mk(OP_LOAD, 4095, 32'hFFFF_FFFF, 1'b1));     // beyond row_count
        offer_item(mk(OP_SPARE, 4095, 32'hFFFF_FFFF, 1'b1));    // unused code
        offer_item(mk(OP_RESP, 0, Q_ONE, 1'b0));                // nothing outstanding
        offer_item(mk(OP_MATRIX, 1, 32'h0, 1'b0));              // header, b never written
        offer_item(mk(OP_MATRIX, 0, Q_ONE, 1'b0));
        offer_item(mk(OP_MATRIX, 2, Q_ONE, 1'b0));              // dropped while waiting
        offer_item(mk(OP_RESP, 0, 32'h7FFF_FFFF, 1'b0));
        offer_item(mk(OP_LOAD, 1, -Q_ONE, 1'b0));               // open row keeps its b
        offer_item(mk(OP_MATRIX, 1, 32'h0, 1'b0));              // zero diagonal
        offer_item(mk(OP_MATRIX, 7, 32'h0, 1'b0));
        offer_item(mk(OP_MATRIX, 0, 32'h8000_0000, 1'b0));
        offer_item(mk(OP_RESP, 0, 32'h8000_0000, 1'b0));        // largest product
        offer_item(mk(OP_MATRIX, 7, 32'h0000_0001, 1'b0));      // saturates low
        offer_item(mk(OP_MATRIX, 0, 32'h0, 1'b0));
        offer_item(mk(OP_MATRIX, 0, Q_ONE, 1'b0));              // x = b, max positive
        offer_item(mk(OP_MATRIX, 3, 32'h0, 1'b1));              // header with end mark
        offer_item(mk(OP_MATRIX, 2, 32'h0, 1'b0));
        offer_item(mk(OP_MATRIX, 0, -Q_ONE, 1'b1));             // request, then row abandoned
        offer_item(mk(OP_RESP, 0, Q_ONE, 1'b0));                // ignored after abandon
        offer_item(mk(OP_MATRIX, 4095, 32'h0, 1'b0));
        offer_item(mk(OP_MATRIX, 4095, 32'hFFFF_FFFF, 1'b1));   // zero difference
        settle();

        // Random phases across row_count settings
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0, 2, 7: rows = MAX_ROWS;
                1:       rows = 1;
                3:       rows = 0;
                5:       rows = 2;
                default: rows = $urandom_range(2, MAX_ROWS - 1);
            endcase
            set_row_count(rows);
            calm   = (p == 3) || (p == 6);
            target = useful + 125;
            if (p == 2)
            begin
                // hold the output off while loads keep coming, so the input backs up
                freeze_cycles = 400;
                load_rhs(40);
            end
            while (useful < target)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    load_rhs($urandom_range(1, 6));
                    2:       broken_row();
                    3:       noise();
                    default: solve_row();
                endcase
                if (p == 4 && !paused_once && useful >= target - 75)
                begin
                    settle();
                    paused_once = 1'b1;
                end
            end
            settle();
        end

        $display("Sent %0d input transactions under %0d row_count settings, idle and stall gaps",
                 n_sent, n_settings);
        $display("Checked %0d forwarded b, %0d requests, %0d solved rows (%0d flagged)",
                 sb.n_rhs, sb.n_req, sb.n_sol, sb.n_fault);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
